>>> design/assert_macros.svh
// assertion macros for the rtl files, used by rwes_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/rwes_pkg.sv
// shared types and constants of the rate weighted event select block
`timescale 1ns / 1ps

package rwes_pkg;

    // width of the uniform fraction that comes with a select transaction
    localparam int FRAC_BITS = 32;
    localparam int MUL_CNT_W = $clog2(FRAC_BITS);

    // function codes of an input transaction
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic wr_commit;
        logic mul_step;
        logic walk_start;
        logic walk_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic no_active;
        logic mul_last;
        logic walk_done;
    } t_status;

endpackage

>>> design/rwes_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rwes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rwes_ctrl.sv
// controller state machine of the rate weighted event select block
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rwes_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_func,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rwes_pkg::t_cmd    o_cmd,
    input  rwes_pkg::t_status i_sts
);

    import rwes_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_RD,
        S_WR_UPD,
        S_MUL,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_func == FUNC_WRITE) begin
                        n_state = S_WR_RD;
                    end else if (i_sts.no_active) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_WR_RD: begin
                n_state = S_WR_UPD;
            end
            S_WR_UPD: begin
                o_cmd.wr_commit = 1'b1;
                n_state = S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    o_cmd.walk_start = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // hold the walk position once the pick is known
                if (i_sts.walk_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load && r_out_valid, i_out_ready)
    `ASSERT_NEXT(a_mul_to_walk, i_clk, i_rst_n, (r_state == S_MUL) && i_sts.mul_last, r_state == S_WALK)
    `ASSERT_NEXT(a_empty_select, i_clk, i_rst_n, o_in_ready && i_in_valid && (i_func == FUNC_SELECT) && i_sts.no_active, r_state == S_FINISH)
    `ASSERT_IMPLIES(a_valid_rise, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_FINISH))

endmodule

>>> design/rwes_dp.sv
// datapath of the rate weighted event select block: table, total, multiply and walk
`timescale 1ns / 1ps

module rwes_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int RATE_BITS   = 32,
    localparam int IDX_W   = $clog2(TABLE_DEPTH),
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int TOTAL_W = RATE_BITS + IDX_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [COUNT_W-1:0]            i_cfg_wdata,
    input  logic [IDX_W-1:0]              i_entry_index,
    input  logic [RATE_BITS-1:0]          i_rate,
    input  logic [rwes_pkg::FRAC_BITS-1:0] i_random_fraction,
    output logic [IDX_W-1:0]              o_event_index,
    output logic                          o_no_event,
    output logic [TOTAL_W-1:0]            o_total_rate,
    input  rwes_pkg::t_cmd                i_cmd,
    output rwes_pkg::t_status             o_sts
);

    import rwes_pkg::*;

    localparam int ACC_W = TOTAL_W + FRAC_BITS;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);
    localparam int RESET_N = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024;

    // configuration: last entry that takes part in selection
    logic [IDX_W-1:0]     r_last_idx;
    // table bookkeeping
    logic [IDX_W-1:0]     r_caddr;
    logic [TOTAL_W-1:0]   r_total;
    logic [COUNT_W-1:0]   r_count;
    // captured transaction
    logic [IDX_W-1:0]     r_idx;
    logic [RATE_BITS-1:0] r_rate;
    // shift-add multiplier
    logic [ACC_W-1:0]     r_acc;
    logic [FRAC_BITS-1:0] r_frac;
    logic [MUL_CNT_W-1:0] r_mcnt;
    // cumulative walk
    logic [IDX_W-1:0]     r_raddr;
    logic [IDX_W-1:0]     r_didx;
    logic                 r_dvld;
    logic [TOTAL_W-1:0]   r_partial;
    // result register
    logic [IDX_W-1:0]     r_out_idx;
    logic                 r_out_none;
    logic [TOTAL_W-1:0]   r_out_total;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [RATE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [RATE_BITS-1:0] ram_rdata;

    logic                 idx_ok;
    logic [TOTAL_W-1:0]   n_total;
    logic [COUNT_W-1:0]   n_count;
    logic [TOTAL_W:0]     n_msum;
    logic [TOTAL_W-1:0]   target;
    logic [TOTAL_W-1:0]   n_psum;
    logic                 walk_hit;
    logic                 walk_last;
    logic [IDX_W-1:0]     n_last_idx;

    rwes_ram #(
        .WIDTH (RATE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_ok = ({1'b0, r_idx} < (IDX_W + 1)'(TABLE_DEPTH));

    assign ram_we    = i_cmd.clr_step | (i_cmd.wr_commit & idx_ok);
    assign ram_waddr = i_cmd.clr_step ? r_caddr : r_idx;
    assign ram_wdata = i_cmd.clr_step ? '0 : r_rate;
    assign ram_raddr = i_cmd.walk_step ? r_raddr : r_idx;

    // old entry value is on ram_rdata during the commit cycle
    assign n_total = r_total - TOTAL_W'(ram_rdata) + TOTAL_W'(r_rate);
    assign n_count = r_count - COUNT_W'(ram_rdata != '0) + COUNT_W'(r_rate != '0);

    assign n_msum = {1'b0, r_acc[ACC_W-1 -: TOTAL_W]}
                  + (r_frac[0] ? {1'b0, r_total} : '0);
    assign target = r_acc[ACC_W-1 -: TOTAL_W];

    assign n_psum    = r_partial + TOTAL_W'(ram_rdata);
    assign walk_hit  = (n_psum > target);
    assign walk_last = (r_didx == r_last_idx);

    // zero means one entry, above the depth means all of them
    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            n_last_idx = '0;
        end else if (i_cfg_wdata > DEPTH_C) begin
            n_last_idx = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            n_last_idx = IDX_W'(i_cfg_wdata - COUNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= IDX_W'(RESET_N - 1);
            r_caddr    <= '0;
            r_total    <= '0;
            r_count    <= '0;
            r_dvld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_last_idx <= n_last_idx;
            end
            if (i_cmd.clr_step) begin
                r_caddr <= r_caddr + IDX_W'(1);
            end
            if (i_cmd.wr_commit && idx_ok) begin
                r_total <= n_total;
                r_count <= n_count;
            end
            if (i_cmd.walk_start) begin
                r_dvld <= 1'b0;
            end else if (i_cmd.walk_step) begin
                r_dvld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx  <= i_entry_index;
            r_rate <= i_rate;
            r_frac <= i_random_fraction;
            r_acc  <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc  <= {n_msum, r_acc[FRAC_BITS-1:1]};
            r_frac <= r_frac >> 1;
            r_mcnt <= r_mcnt + MUL_CNT_W'(1);
        end
        if (i_cmd.walk_start) begin
            r_raddr   <= '0;
            r_partial <= '0;
        end else if (i_cmd.walk_step) begin
            r_raddr <= r_raddr + IDX_W'(1);
            r_didx  <= r_raddr;
            if (r_dvld) begin
                r_partial <= n_psum;
            end
        end
        if (i_cmd.out_load) begin
            r_out_none  <= (r_count == '0);
            r_out_idx   <= (r_count == '0) ? '0 : r_didx;
            r_out_total <= (r_count == '0) ? '0 : r_total;
        end
    end

    assign o_sts.clr_last  = (r_caddr == IDX_W'(TABLE_DEPTH - 1));
    assign o_sts.no_active = (r_count == '0);
    assign o_sts.mul_last  = (r_mcnt == MUL_CNT_W'(FRAC_BITS - 1));
    assign o_sts.walk_done = r_dvld & (walk_hit | walk_last);

    assign o_event_index = r_out_idx;
    assign o_no_event    = r_out_none;
    assign o_total_rate  = r_out_total;

endmodule

>>> design/rate_weighted_event_select.sv
// top level of the rate weighted event select block
//
//  channel  | valid / enable | ready       | payload
//  ---------+----------------+-------------+--------------------------------------------
//  input    | i_in_valid     | o_in_ready  | i_func, i_entry_index, i_rate, i_random_fraction
//  output   | o_out_valid    | i_out_ready | o_event_index, o_no_event, o_total_rate
//  config   | i_cfg_we       | none        | i_cfg_wdata (entries in use)
//
//  after reset a clearing pass zeroes every table entry before o_in_ready rises
//  a write transaction captures its operands, reads the old rate from the table, then updates
//  a select transaction captures its operands, multiplies the total by the fraction in the
//  shift-add multiplier, then walks the table; the walk reads one table entry per cycle
//  with no active entry a select skips the multiply and the walk; one result register lets the next
//  transaction be taken while a result waits, a select stalls at its end until it is free
`timescale 1ns / 1ps

module rate_weighted_event_select #(
    parameter int TABLE_DEPTH = 1024,
    parameter int RATE_BITS   = 32,
    localparam int IDX_W   = $clog2(TABLE_DEPTH),
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int TOTAL_W = RATE_BITS + IDX_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [COUNT_W-1:0]             i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_func,
    input  logic [IDX_W-1:0]               i_entry_index,
    input  logic [RATE_BITS-1:0]           i_rate,
    input  logic [rwes_pkg::FRAC_BITS-1:0] i_random_fraction,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [IDX_W-1:0]               o_event_index,
    output logic                           o_no_event,
    output logic [TOTAL_W-1:0]             o_total_rate
);

    import rwes_pkg::*;

    t_cmd    cmd;
    t_status sts;

    rwes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rwes_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .RATE_BITS   (RATE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_entry_index     (i_entry_index),
        .i_rate            (i_rate),
        .i_random_fraction (i_random_fraction),
        .o_event_index     (o_event_index),
        .o_no_event        (o_no_event),
        .o_total_rate      (o_total_rate),
        .i_cmd             (cmd),
        .o_sts             (sts)
    );

endmodule
